FILE: design/linear_blend_skinning_assert.svh
// assertion macros for the skinning engine
// used at the end of the top level
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbs check failed");
`define LBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbs check failed");
`endif

FILE: design/lbs_pkg.sv
// package for the skinning engine: constants, command codes, states
// no dependencies
`default_nettype none
package lbs_pkg;
  localparam int MAX_VERTICES = 4096;
  localparam int MAX_BONES = 64;
  localparam int FRAC_BITS = 16;
  localparam int VC_W = 13;
  localparam int BC_W = 7;
  localparam int VI_W = 12;
  localparam int BI_W = 6;
  localparam int CFG_W = 13;

  typedef enum logic [2:0] {
    FN_LOAD_REST = 3'd0, FN_LOAD_BIND = 3'd1, FN_LOAD_TARGET = 3'd2,
    FN_COMPOSE = 3'd3, FN_APPLY = 3'd4, FN_CLEAR = 3'd5, FN_READ = 3'd6,
    FN_NOP = 3'd7
  } func_t;

  typedef enum logic {
    CFG_VERTEX_COUNT = 1'b0, CFG_BONE_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_REST_WR, ST_COMP_RD, ST_COMP_MAC, ST_COMP_WR,
    ST_APP_RD, ST_APP_MAC, ST_APP_W, ST_APP_ACC, ST_APP_WR, ST_RD_RD,
    ST_RD_CAP, ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fffffff;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: design/lbs_if.sv
// valid/ready channel interfaces for commands and results
// no dependencies
`default_nettype none
interface lbs_cmd_if;
  logic valid;
  logic ready;
  logic [2:0] func;
  logic [11:0] vertex_index;
  logic [5:0] bone_index;
  logic [3:0] element;
  logic signed [31:0] matrix_value;
  logic [16:0] weight;
  logic signed [31:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
  modport source (output valid, func, vertex_index, bone_index, element, matrix_value,
    weight, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, func, vertex_index, bone_index, element, matrix_value,
    weight, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface lbs_res_if;
  logic valid;
  logic ready;
  logic [11:0] out_vertex;
  logic signed [31:0] skin_x, skin_y, skin_z, skin_nx, skin_ny, skin_nz;
  modport source (output valid, out_vertex, skin_x, skin_y, skin_z, skin_nx, skin_ny,
    skin_nz, input ready);
  modport sink (input valid, out_vertex, skin_x, skin_y, skin_z, skin_nx, skin_ny,
    skin_nz, output ready);
endinterface
`default_nettype wire

FILE: design/lbs_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: design/lbs_mac.sv
// shared rounding multiplier: p = round(a*b >> frac), or >> 16 when wmode is set, registered
// uses lbs_pkg
`default_nettype none
module lbs_mac #(
  parameter int FRAC = lbs_pkg::FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic               wmode,
  output logic signed [47:0]      p
);
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  always_comb begin
    prod = a * b;
    if (wmode) rnd = (prod + 64'sd32768) >>> 16;
    else rnd = (prod + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  end
  always_ff @(posedge clk) begin
    p <= rnd[47:0];
  end
endmodule
`default_nettype wire

FILE: design/linear_blend_skinning.sv
// Skinning engine: one command at a time, sequenced around one shared multiplier.
// Rest loads write x at the transfer and y, z in ST_REST_WR; bind and target loads finish
// at the transfer. Compose, apply and read then run their states; read waits in ST_OUT.
// Clear sweeps all MAX_VERTICES*3 accumulator rows, one per cycle.
// After rst the same clearing sweep runs before the first command is taken;
// counters, config counts and target reset to zero, bone matrix to identity.
`default_nettype none
`include "linear_blend_skinning_assert.svh"
module linear_blend_skinning #(
  parameter int MAX_VERTICES = lbs_pkg::MAX_VERTICES,
  parameter int MAX_BONES = lbs_pkg::MAX_BONES,
  parameter int FRAC_BITS = lbs_pkg::FRAC_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  lbs_cmd_if.sink                       cmd,
  lbs_res_if.source                     res,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [lbs_pkg::CFG_W-1:0] cfg_data
);
  localparam int VD = MAX_VERTICES * 3;
  localparam int VA = $clog2(VD);
  localparam int BD = MAX_BONES * 16;
  localparam int BA = $clog2(BD);
  localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  lbs_pkg::state_t state, state_next;
  logic [lbs_pkg::VC_W-1:0] vertex_count;
  logic [lbs_pkg::BC_W-1:0] bone_count;
  logic [2:0] func;
  logic [11:0] vidx;
  logic [5:0] bidx;
  logic [16:0] wgt;
  logic [VA-1:0] cnt;
  logic [1:0] r, c, k;
  logic [1:0] ph;
  logic signed [31:0] target [16];
  logic signed [31:0] bone [16];
  logic signed [31:0] rp [3];
  logic signed [31:0] rn [3];
  logic signed [31:0] rdv [6];
  logic signed [49:0] sp, sn;
  logic signed [31:0] tp, tn;
  logic signed [31:0] ma, mb;
  logic wm;
  logic signed [47:0] mp;

  // memories
  logic rp_we, rn_we, sp_we, sn_we, bd_we;
  logic [VA-1:0] va;
  logic [BA-1:0] ba;
  logic signed [31:0] rp_wd, rn_wd, sp_wd, sn_wd;
  logic [31:0] rp_q, rn_q, sp_q, sn_q, bd_q;

  lbs_ram #(.WIDTH(32), .DEPTH(VD)) u_rp (.clk, .we(rp_we), .addr(va), .wdata(rp_wd),
    .rdata(rp_q));
  lbs_ram #(.WIDTH(32), .DEPTH(VD)) u_rn (.clk, .we(rn_we), .addr(va), .wdata(rn_wd),
    .rdata(rn_q));
  lbs_ram #(.WIDTH(32), .DEPTH(VD)) u_sp (.clk, .we(sp_we), .addr(va), .wdata(sp_wd),
    .rdata(sp_q));
  lbs_ram #(.WIDTH(32), .DEPTH(VD)) u_sn (.clk, .we(sn_we), .addr(va), .wdata(sn_wd),
    .rdata(sn_q));
  lbs_ram #(.WIDTH(32), .DEPTH(BD)) u_bd (.clk, .we(bd_we), .addr(ba), .wdata(cmd.matrix_value),
    .rdata(bd_q));

  lbs_mac #(.FRAC(FRAC_BITS)) u_mac (.clk, .a(ma), .b(mb), .wmode(wm), .p(mp));

  logic v_ok_in, b_ok_in, acc;
  assign v_ok_in = ({1'b0, cmd.vertex_index} < vertex_count) &&
                   (32'(cmd.vertex_index) < MAX_VERTICES);
  assign b_ok_in = ({1'b0, cmd.bone_index} < bone_count) &&
                   (32'(cmd.bone_index) < MAX_BONES);
  assign cmd.ready = (state == lbs_pkg::ST_IDLE);
  assign acc = cmd.valid && cmd.ready;

  logic [VA+1:0] vbase_in, vbase;
  assign vbase_in = (VA+2)'(cmd.vertex_index) * (VA+2)'(3);
  assign vbase = (VA+2)'(vidx) * (VA+2)'(3);
  logic [BA+5:0] bbase;
  assign bbase = (BA+6)'(bidx) << 4;

  always_comb begin
    va = '0;
    ba = '0;
    rp_we = 1'b0; rn_we = 1'b0; sp_we = 1'b0; sn_we = 1'b0; bd_we = 1'b0;
    rp_wd = cmd.pos_x; rn_wd = cmd.norm_x; sp_wd = '0; sn_wd = '0;
    ma = '0; mb = '0; wm = 1'b0;
    unique case (state)
      lbs_pkg::ST_IDLE: begin
        va = vbase_in[VA-1:0];
        ba = BA'((BA+6)'(cmd.bone_index) * (BA+6)'(16) + (BA+6)'(cmd.element));
        if (acc && cmd.func == lbs_pkg::FN_LOAD_REST && v_ok_in) begin
          rp_we = 1'b1; rn_we = 1'b1;
        end
        if (acc && cmd.func == lbs_pkg::FN_LOAD_BIND && b_ok_in) bd_we = 1'b1;
      end
      lbs_pkg::ST_CLEAR: begin
        va = cnt; sp_we = 1'b1; sn_we = 1'b1;
      end
      lbs_pkg::ST_REST_WR: begin
        va = VA'(vbase + (VA+2)'(cnt));
        rp_we = 1'b1; rn_we = 1'b1;
        rp_wd = (cnt[0]) ? rp[1] : rp[2];
        rn_wd = (cnt[0]) ? rn[1] : rn[2];
      end
      lbs_pkg::ST_COMP_RD, lbs_pkg::ST_COMP_MAC: begin
        ba = BA'(bbase + (BA+6)'({k, c}));
        ma = target[{r, k}];
        mb = bd_q;
      end
      lbs_pkg::ST_APP_RD, lbs_pkg::ST_RD_RD: begin
        va = VA'(vbase + (VA+2)'(c));
      end
      lbs_pkg::ST_APP_MAC: begin
        va = VA'(vbase + (VA+2)'(r));
        ma = bone[{r, c}];
        mb = ph[0] ? rn[c] : rp[c];
      end
      lbs_pkg::ST_APP_W: begin
        va = VA'(vbase + (VA+2)'(r));
        wm = 1'b1;
        ma = {15'd0, wgt};
        mb = ph[0] ? tn : tp;
      end
      lbs_pkg::ST_APP_ACC: begin
        va = VA'(vbase + (VA+2)'(r));
      end
      lbs_pkg::ST_APP_WR: begin
        va = VA'(vbase + (VA+2)'(r));
        sp_we = 1'b1; sn_we = 1'b1;
        sp_wd = lbs_pkg::sat32(50'(signed'(sp_q)) + sp);
        sn_wd = lbs_pkg::sat32(50'(signed'(sn_q)) + sn);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lbs_pkg::ST_IDLE:
        if (acc) begin
          unique case (cmd.func)
            lbs_pkg::FN_LOAD_REST: if (v_ok_in) state_next = lbs_pkg::ST_REST_WR;
            lbs_pkg::FN_COMPOSE: if (b_ok_in) state_next = lbs_pkg::ST_COMP_RD;
            lbs_pkg::FN_APPLY:
              if (v_ok_in && bone_count != '0) state_next = lbs_pkg::ST_APP_RD;
            lbs_pkg::FN_CLEAR: state_next = lbs_pkg::ST_CLEAR;
            lbs_pkg::FN_READ: if (v_ok_in) state_next = lbs_pkg::ST_RD_RD;
            default: ;
          endcase
        end
      lbs_pkg::ST_CLEAR: if (cnt == VA'(VD - 1)) state_next = lbs_pkg::ST_IDLE;
      lbs_pkg::ST_REST_WR: if (cnt == VA'(2)) state_next = lbs_pkg::ST_IDLE;
      lbs_pkg::ST_COMP_RD: state_next = lbs_pkg::ST_COMP_MAC;
      lbs_pkg::ST_COMP_MAC:
        if (ph == 2'd1) state_next = (k == 2'd3) ? lbs_pkg::ST_COMP_WR : lbs_pkg::ST_COMP_RD;
      lbs_pkg::ST_COMP_WR:
        state_next = (r == 2'd3 && c == 2'd3) ? lbs_pkg::ST_IDLE : lbs_pkg::ST_COMP_RD;
      lbs_pkg::ST_APP_RD: if (c == 2'd2 && ph == 2'd1) state_next = lbs_pkg::ST_APP_MAC;
      lbs_pkg::ST_APP_MAC:
        if (c == 2'd2 && ph == 2'd3) state_next = lbs_pkg::ST_APP_W;
      lbs_pkg::ST_APP_W: if (ph == 2'd3) state_next = lbs_pkg::ST_APP_ACC;
      lbs_pkg::ST_APP_ACC: state_next = lbs_pkg::ST_APP_WR;
      lbs_pkg::ST_APP_WR:
        state_next = (r == 2'd2) ? lbs_pkg::ST_IDLE : lbs_pkg::ST_APP_MAC;
      lbs_pkg::ST_RD_RD: if (c == 2'd2 && ph == 2'd1) state_next = lbs_pkg::ST_OUT;
      lbs_pkg::ST_RD_CAP: state_next = lbs_pkg::ST_OUT;
      lbs_pkg::ST_OUT: if (res.ready) state_next = lbs_pkg::ST_IDLE;
      default: state_next = lbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::ST_CLEAR;
      cnt <= '0;
      vertex_count <= '0;
      bone_count <= '0;
      r <= '0; c <= '0; k <= '0; ph <= '0;
      for (int i = 0; i < 16; i++) begin
        target[i] <= '0;
        bone[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          lbs_pkg::CFG_VERTEX_COUNT: vertex_count <= cfg_data;
          lbs_pkg::CFG_BONE_COUNT: bone_count <= cfg_data[lbs_pkg::BC_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        lbs_pkg::ST_IDLE: begin
          cnt <= (acc && cmd.func == lbs_pkg::FN_LOAD_REST) ? VA'(1) : '0;
          r <= '0; c <= '0; k <= '0; ph <= '0;
          sp <= '0; sn <= '0;
          if (acc) begin
            func <= cmd.func; vidx <= cmd.vertex_index; bidx <= cmd.bone_index;
            wgt <= (cmd.weight > 17'd65536) ? 17'd65536 : cmd.weight;
            rp[1] <= cmd.pos_y; rp[2] <= cmd.pos_z;
            rn[1] <= cmd.norm_y; rn[2] <= cmd.norm_z;
            if (cmd.func == lbs_pkg::FN_LOAD_TARGET) target[cmd.element] <= cmd.matrix_value;
          end
        end
        lbs_pkg::ST_CLEAR, lbs_pkg::ST_REST_WR: cnt <= cnt + VA'(1);
        lbs_pkg::ST_COMP_RD: ph <= '0;
        lbs_pkg::ST_COMP_MAC: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            sp <= sp + 50'(mp);
            k <= k + 2'd1;
          end
        end
        lbs_pkg::ST_COMP_WR: begin
          bone[{r, c}] <= lbs_pkg::sat32(sp);
          sp <= '0;
          c <= c + 2'd1;
          if (c == 2'd3) r <= r + 2'd1;
        end
        lbs_pkg::ST_APP_RD, lbs_pkg::ST_RD_RD: begin
          if (ph == 2'd1) begin
            rp[c] <= rp_q; rn[c] <= rn_q;
            rdv[3'(c)] <= sp_q; rdv[3'd3 + 3'(c)] <= sn_q;
            ph <= '0;
            c <= (c == 2'd2) ? 2'd0 : c + 2'd1;
          end else begin
            ph <= ph + 2'd1;
          end
          if (state == lbs_pkg::ST_APP_RD && c == 2'd2 && ph == 2'd1) begin
            sp <= 50'(bone[{2'd0, 2'd3}]);
          end
        end
        lbs_pkg::ST_APP_MAC: begin
          // ph 0: issue position product, 1: issue normal and take position, 2: take normal
          ph <= ph + 2'd1;
          if (ph == 2'd1) sp <= sp + 50'(mp);
          if (ph == 2'd2) sn <= sn + 50'(mp);
          if (ph == 2'd3) begin
            c <= (c == 2'd2) ? 2'd0 : c + 2'd1;
            if (c == 2'd2) begin
              tp <= lbs_pkg::sat32(sp);
              tn <= lbs_pkg::sat32(sn);
            end
          end
        end
        lbs_pkg::ST_APP_W: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) sp <= 50'(mp);
          if (ph == 2'd2) sn <= 50'(mp);
        end
        lbs_pkg::ST_APP_WR: begin
          r <= r + 2'd1;
          sp <= 50'(bone[{r + 2'd1, 2'd3}]);
          sn <= '0;
        end
        default: ;
      endcase
    end
  end

  assign res.valid = (state == lbs_pkg::ST_OUT);
  assign res.out_vertex = vidx;
  assign res.skin_x = rdv[0];
  assign res.skin_y = rdv[1];
  assign res.skin_z = rdv[2];
  assign res.skin_nx = rdv[3];
  assign res.skin_ny = rdv[4];
  assign res.skin_nz = rdv[5];

  logic unused;
  assign unused = ^{func, VW, BW};

  `LBS_ASSERT_IMPL(a_ready_idle, clk, rst, res.valid, !cmd.ready)
  `LBS_ASSERT_NEXT(a_out_hold, clk, rst, res.valid && !res.ready, res.valid)
  `LBS_ASSERT_IMPL(a_no_write_out, clk, rst, res.valid, !sp_we && !rp_we)
endmodule
`default_nettype wire
